### rtl/bset_pkg.sv
package bset_pkg;

  localparam int FRAC_BITS  = 28;
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  localparam int PIX_W      = 12;
  localparam int CNT_W      = 16;
  localparam int ORIGIN_W   = 32;
  localparam int STEP_W     = 31;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  // step * pixel, c = origin + step * pixel, z with headroom over c
  localparam int SPROD_W = STEP_W + PIX_W;
  localparam int C_W     = SPROD_W + 2;
  localparam int Z_W     = C_W + 1;
  // magnitude below 2.0 and its square
  localparam int MAG_W   = FRAC_BITS + 1;
  localparam int PROD_W  = 2 * MAG_W;
  localparam int SH_W    = PROD_W + 1 - FRAC_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_RE = 3'd0,
    REG_ORIGIN_IM = 3'd1,
    REG_STEP_RE   = 3'd2,
    REG_STEP_IM   = 3'd3,
    REG_MAX_ITER  = 3'd4
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SQUARE = 4'b0010,
    S_UPDATE = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  typedef struct packed {
    logic load;
    logic square;
    logic update;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic iterate;
  } status_t;

endpackage

### rtl/bset_ctrl.sv
module bset_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  bset_pkg::status_t status,
  output bset_pkg::cmd_t    cmd
);

  bset_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    unique case (state_r)
      bset_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = bset_pkg::S_SQUARE;
        end
      end
      bset_pkg::S_SQUARE: begin
        cmd.square = 1'b1;
        state_nxt  = bset_pkg::S_UPDATE;
      end
      bset_pkg::S_UPDATE: begin
        cmd.update = status.iterate;
        state_nxt  = status.iterate ? bset_pkg::S_SQUARE : bset_pkg::S_FINISH;
      end
      bset_pkg::S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = bset_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bset_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bset_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### rtl/bset_datapath.sv
module bset_datapath (
  input  logic                                clk,
  input  bset_pkg::cmd_t                      cmd,
  input  logic signed [bset_pkg::ORIGIN_W-1:0] origin_re,
  input  logic signed [bset_pkg::ORIGIN_W-1:0] origin_im,
  input  logic        [bset_pkg::STEP_W-1:0]   step_re,
  input  logic        [bset_pkg::STEP_W-1:0]   step_im,
  input  logic        [bset_pkg::CNT_W-1:0]    iter_max,
  input  logic        [bset_pkg::PIX_W-1:0]    in_pixel_x,
  input  logic        [bset_pkg::PIX_W-1:0]    in_pixel_y,
  output logic        [bset_pkg::PIX_W-1:0]    out_x,
  output logic        [bset_pkg::PIX_W-1:0]    out_y,
  output logic        [bset_pkg::CNT_W-1:0]    out_iteration_count,
  output logic                                out_in_set,
  output bset_pkg::status_t                   status
);

  localparam int PIX_W   = bset_pkg::PIX_W;
  localparam int CNT_W   = bset_pkg::CNT_W;
  localparam int SPROD_W = bset_pkg::SPROD_W;
  localparam int C_W     = bset_pkg::C_W;
  localparam int Z_W     = bset_pkg::Z_W;
  localparam int MAG_W   = bset_pkg::MAG_W;
  localparam int PROD_W  = bset_pkg::PROD_W;
  localparam int SH_W    = bset_pkg::SH_W;
  localparam int FRAC    = bset_pkg::FRAC_BITS;

  logic        [PIX_W-1:0]  px_r, py_r;
  logic signed [C_W-1:0]    cre_r, cim_r;
  logic signed [Z_W-1:0]    zre_r, zim_r;
  logic        [CNT_W-1:0]  count_r;
  logic        [PROD_W-1:0] aa_r, bb_r, ab_r;
  logic                     big_r;

  logic        [PIX_W-1:0]   col, row;
  logic        [SPROD_W-1:0] sx, sy;
  logic        [Z_W-1:0]     a_abs, b_abs;
  logic        [MAG_W-1:0]   a_m, b_m;
  logic                      big;
  logic        [PROD_W:0]    sum_sq;
  logic signed [PROD_W:0]    diff;
  logic signed [SH_W-1:0]    re_sh;
  logic signed [SH_W:0]      im_sh;
  logic                      in_radius;

  // point mapping
  assign col = PIX_W'(in_pixel_x % bset_pkg::MAX_WIDTH);
  assign row = PIX_W'(in_pixel_y % bset_pkg::MAX_HEIGHT);
  assign sx  = SPROD_W'(step_re) * SPROD_W'(col);
  assign sy  = SPROD_W'(step_im) * SPROD_W'(row);

  // folded magnitudes
  assign a_abs = zre_r[Z_W-1] ? Z_W'(-zre_r) : Z_W'(zre_r);
  assign b_abs = zim_r[Z_W-1] ? Z_W'(-zim_r) : Z_W'(zim_r);
  assign a_m   = a_abs[MAG_W-1:0];
  assign b_m   = b_abs[MAG_W-1:0];
  assign big   = (|a_abs[Z_W-1:MAG_W]) | (|b_abs[Z_W-1:MAG_W]);

  // escape test and next z
  assign sum_sq    = {1'b0, aa_r} + {1'b0, bb_r};
  assign in_radius = ~big_r & ~sum_sq[PROD_W];
  assign diff      = $signed({1'b0, aa_r}) - $signed({1'b0, bb_r});
  assign re_sh     = diff[PROD_W:FRAC];
  assign im_sh     = {1'b0, ab_r[PROD_W-1:FRAC-1]};

  assign status.iterate = (count_r < iter_max) & in_radius;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px_r    <= in_pixel_x;
      py_r    <= in_pixel_y;
      cre_r   <= C_W'(origin_re) + C_W'(sx);
      cim_r   <= C_W'(origin_im) + C_W'(sy);
      zre_r   <= '0;
      zim_r   <= '0;
      count_r <= '0;
    end else if (cmd.update) begin
      zre_r   <= Z_W'(re_sh) + Z_W'(cre_r);
      zim_r   <= Z_W'(im_sh) + Z_W'(cim_r);
      count_r <= count_r + CNT_W'(1);
    end
    if (cmd.square) begin
      aa_r  <= PROD_W'(a_m) * PROD_W'(a_m);
      bb_r  <= PROD_W'(b_m) * PROD_W'(b_m);
      ab_r  <= PROD_W'(a_m) * PROD_W'(b_m);
      big_r <= big;
    end
    if (cmd.emit) begin
      out_x               <= px_r;
      out_y               <= py_r;
      out_iteration_count <= count_r;
      out_in_set          <= (count_r == iter_max);
    end
  end

endmodule

### rtl/burning_ship_escape_time_core.sv
// Burning Ship escape-time engine: each in_ beat carries one pixel, which is
// mapped to c = origin + step * pixel in Q17.28 and iterated from z = 0 until
// |z|^2 reaches 4 or the iteration limit is hit; one out_ beat returns the pixel,
// the count and the in-set flag. One pixel is in flight at a time; its result
// waits in the finish state while the previous result still waits to be taken.
// Each iteration passes through three 29x29 multipliers in the square state and
// then the escape test and z update in the update state. A finished result sits
// in the output register so the next pixel is taken while it waits. The user is
// bound to write registers through cfg_ only while no pixel is in flight and no
// result is pending; the core itself does not enforce this.
module burning_ship_escape_time_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [bset_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bset_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [bset_pkg::PIX_W-1:0]        in_pixel_x,
  input  logic [bset_pkg::PIX_W-1:0]        in_pixel_y,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bset_pkg::PIX_W-1:0]        out_x,
  output logic [bset_pkg::PIX_W-1:0]        out_y,
  output logic [bset_pkg::CNT_W-1:0]        out_iteration_count,
  output logic                              out_in_set
);

  logic signed [bset_pkg::ORIGIN_W-1:0] origin_re_r, origin_im_r;
  logic        [bset_pkg::STEP_W-1:0]   step_re_r, step_im_r;
  logic        [bset_pkg::CNT_W-1:0]    max_iter_r;

  bset_pkg::cmd_t    cmd;
  bset_pkg::status_t status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_re_r <= -32'sd536870912;
      origin_im_r <= -32'sd536870912;
      step_re_r   <= 31'd1049616;
      step_im_r   <= 31'd1049616;
      max_iter_r  <= 16'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bset_pkg::REG_ORIGIN_RE: origin_re_r <= cfg_wdata[bset_pkg::ORIGIN_W-1:0];
        bset_pkg::REG_ORIGIN_IM: origin_im_r <= cfg_wdata[bset_pkg::ORIGIN_W-1:0];
        bset_pkg::REG_STEP_RE:   step_re_r   <= cfg_wdata[bset_pkg::STEP_W-1:0];
        bset_pkg::REG_STEP_IM:   step_im_r   <= cfg_wdata[bset_pkg::STEP_W-1:0];
        bset_pkg::REG_MAX_ITER:  max_iter_r  <= cfg_wdata[bset_pkg::CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  bset_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  bset_datapath u_datapath (
    .clk                 (clk),
    .cmd                 (cmd),
    .origin_re           (origin_re_r),
    .origin_im           (origin_im_r),
    .step_re             (step_re_r),
    .step_im             (step_im_r),
    .iter_max            (max_iter_r),
    .in_pixel_x          (in_pixel_x),
    .in_pixel_y          (in_pixel_y),
    .out_x               (out_x),
    .out_y               (out_y),
    .out_iteration_count (out_iteration_count),
    .out_in_set          (out_in_set),
    .status              (status)
  );

  // one pixel in flight
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("new pixel taken while one is in flight");

  // count never passes the limit
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_iteration_count <= max_iter_r)
    else $error("iteration count above limit");

  // a pixel taken while no result is pending does not raise a result without iterating
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result raised without iterating");

endmodule
